// ===== rtl/core/cmpr_tiled_block_decoder_assert.svh =====
// ============================================================================
// Assertion macros for the tiled block decoder
// Shorthand for clocked implication checks with a common clock and reset.
// ============================================================================
`ifndef CMPR_TILED_BLOCK_DECODER_ASSERT_SVH
`define CMPR_TILED_BLOCK_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ctbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CTBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ctbd assertion failed");

`endif

// ===== rtl/core/ctbd_pkg.sv =====
// ============================================================================
// ctbd_pkg
// Shared types and constants of the tiled block decoder.
// ============================================================================
package ctbd_pkg;

    localparam int MAX_TILES_DEFAULT = 128;
    localparam int QUEUE_DEPTH       = 2;
    localparam int COORD_W           = 10;
    localparam int SIZE_W            = 8;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam logic [0:0] REG_TILES_ACROSS = 1'b0;
    localparam logic [0:0] REG_TILES_DOWN   = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] tiles_across;
        logic [SIZE_W-1:0] tiles_down;
    } ctbd_size_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } ctbd_rgb_t;

    typedef struct packed {
        ctbd_rgb_t [3:0]    palette;
        logic               clear3;
        logic [31:0]        index_rows;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic               image_end;
    } ctbd_block_t;

endpackage

// ===== rtl/core/cmpr_tiled_block_decoder.sv =====
// An accepted item passes the queue slot, the block register and the output register before its
// first pixel is valid. Pixels leave one per cycle while m_ready does not stall them, sixteen per item.
// The two-entry block queue lets the next item be taken while pixels still drain.
// Reset (aresetn low at a clock edge) clears the tile counters, the queue and the
// output valid, and sets both image size registers to one tile.
// ============================================================================
// cmpr_tiled_block_decoder
// Decodes 4x4 color blocks in tiled order into RGBA8 pixels with coordinates.
// ============================================================================
`include "cmpr_tiled_block_decoder_assert.svh"

module cmpr_tiled_block_decoder #(
    parameter int MAX_TILES = ctbd_pkg::MAX_TILES_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_endpoint_first,
    input  logic [15:0]                   s_endpoint_second,
    input  logic [31:0]                   s_index_rows,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ctbd_pkg::COORD_W-1:0]  m_pixel_x,
    output logic [ctbd_pkg::COORD_W-1:0]  m_pixel_y,
    output logic [7:0]                    m_red,
    output logic [7:0]                    m_green,
    output logic [7:0]                    m_blue,
    output logic [7:0]                    m_alpha,
    output logic                          m_last_of_block,
    output logic                          m_last_of_image
);
    import ctbd_pkg::*;

    ctbd_size_t        size_reg, size_next;
    logic [SIZE_W-1:0] clamped;
    logic              cfg_write;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    ctbd_block_t       push_data, pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        clamped = pwdata[SIZE_W-1:0];
        if (clamped == '0) begin
            clamped = SIZE_W'(1);
        end
        if (int'(clamped) > MAX_TILES) begin
            clamped = SIZE_W'(MAX_TILES);
        end
        size_next = size_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_TILES_ACROSS: size_next.tiles_across = clamped;
                REG_TILES_DOWN:   size_next.tiles_down   = clamped;
                default:          size_next = size_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TILES_ACROSS: prdata = 32'(size_reg.tiles_across);
            REG_TILES_DOWN:   prdata = 32'(size_reg.tiles_down);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg.tiles_across <= SIZE_W'(1);
            size_reg.tiles_down   <= SIZE_W'(1);
        end else begin
            size_reg <= size_next;
        end
    end

    ctbd_front #(
        .MAX_TILES(MAX_TILES)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .size              (size_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_endpoint_first  (s_endpoint_first),
        .s_endpoint_second (s_endpoint_second),
        .s_index_rows      (s_index_rows),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_data         (push_data)
    );

    ctbd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ctbd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_alpha         (m_alpha),
        .m_last_of_block (m_last_of_block),
        .m_last_of_image (m_last_of_image)
    );

    `CTBD_ASSERT_SAME(a_image_end_in_block, m_valid && m_last_of_image, m_last_of_block)
    `CTBD_ASSERT_SAME(a_block_end_corner, m_valid && m_last_of_block, (m_pixel_x[1:0] == 2'd3) && (m_pixel_y[1:0] == 2'd3))
    `CTBD_ASSERT_SAME(a_alpha_codes, m_valid, (m_alpha == ALPHA_OPAQUE) || (m_alpha == ALPHA_CLEAR))
    `CTBD_ASSERT_NEXT(a_queue_feeds_back, pop_valid && !m_valid && !u_back.have_reg, u_back.have_reg)

endmodule

// ===== rtl/core/ctbd_front.sv =====
// ============================================================================
// ctbd_front
// Accepts compressed blocks, builds the four-entry palette, and tags each
// block with its image position from the tile and sub-block counters.
// ============================================================================
module ctbd_front #(
    parameter int MAX_TILES = ctbd_pkg::MAX_TILES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctbd_pkg::ctbd_size_t size,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_endpoint_first,
    input  logic [15:0]          s_endpoint_second,
    input  logic [31:0]          s_index_rows,
    output logic                 push_valid,
    input  logic                 push_ready,
    output ctbd_pkg::ctbd_block_t push_data
);
    import ctbd_pkg::*;

    localparam int CW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

    logic [CW-1:0] tile_column_reg, tile_column_next;
    logic [CW-1:0] tile_row_reg, tile_row_next;
    logic [1:0]    sub_block_reg, sub_block_next;
    logic          col_end, row_end, accept;
    ctbd_rgb_t     p0, p1, p2, p3;
    logic          opaque_mode;

    function automatic logic [7:0] mix38(input logic [7:0] p, input logic [7:0] q);
        logic [10:0] sum;
        sum = 11'(p) * 11'd3 + 11'(q) * 11'd5;
        return sum[10:3];
    endfunction

    function automatic logic [7:0] avg(input logic [7:0] p, input logic [7:0] q);
        logic [8:0] sum;
        sum = 9'(p) + 9'(q);
        return sum[8:1];
    endfunction

    function automatic ctbd_rgb_t widen(input logic [15:0] c);
        ctbd_rgb_t w;
        w.red   = {c[15:11], c[15:13]};
        w.green = {c[10:5], c[10:9]};
        w.blue  = {c[4:0], c[4:2]};
        return w;
    endfunction

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    assign col_end = (COORD_W'(tile_column_reg) + COORD_W'(1)) >= COORD_W'(size.tiles_across);
    assign row_end = (COORD_W'(tile_row_reg) + COORD_W'(1)) >= COORD_W'(size.tiles_down);

    always_comb begin
        p0          = widen(s_endpoint_first);
        p1          = widen(s_endpoint_second);
        opaque_mode = s_endpoint_first > s_endpoint_second;
        if (opaque_mode) begin
            p2.red   = mix38(p1.red, p0.red);
            p2.green = mix38(p1.green, p0.green);
            p2.blue  = mix38(p1.blue, p0.blue);
            p3.red   = mix38(p0.red, p1.red);
            p3.green = mix38(p0.green, p1.green);
            p3.blue  = mix38(p0.blue, p1.blue);
        end else begin
            p2.red   = avg(p0.red, p1.red);
            p2.green = avg(p0.green, p1.green);
            p2.blue  = avg(p0.blue, p1.blue);
            p3       = p2;
        end
    end

    always_comb begin
        push_data.palette    = {p3, p2, p1, p0};
        push_data.clear3     = !opaque_mode;
        push_data.index_rows = s_index_rows;
        push_data.base_x     = COORD_W'({tile_column_reg, sub_block_reg[0], 2'b00});
        push_data.base_y     = COORD_W'({tile_row_reg, sub_block_reg[1], 2'b00});
        push_data.image_end  = (sub_block_reg == 2'd3) && col_end && row_end;
    end

    always_comb begin
        tile_column_next = tile_column_reg;
        tile_row_next    = tile_row_reg;
        sub_block_next   = sub_block_reg;
        if (accept) begin
            sub_block_next = sub_block_reg + 2'd1;
            if (sub_block_reg == 2'd3) begin
                if (col_end) begin
                    tile_column_next = '0;
                    tile_row_next    = row_end ? '0 : tile_row_reg + CW'(1);
                end else begin
                    tile_column_next = tile_column_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_column_reg <= '0;
            tile_row_reg    <= '0;
            sub_block_reg   <= '0;
        end else begin
            tile_column_reg <= tile_column_next;
            tile_row_reg    <= tile_row_next;
            sub_block_reg   <= sub_block_next;
        end
    end

endmodule

// ===== rtl/core/ctbd_queue.sv =====
// ============================================================================
// ctbd_queue
// Short first-in first-out queue of decoded blocks between front and back.
// ============================================================================
module ctbd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  ctbd_pkg::ctbd_block_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output ctbd_pkg::ctbd_block_t pop_data
);
    import ctbd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    ctbd_block_t       slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != (PW+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/ctbd_back.sv =====
// ============================================================================
// ctbd_back
// Expands one queued block into sixteen pixels, one per cycle while the
// output is not stalled, through an output register.
// ============================================================================
module ctbd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  ctbd_pkg::ctbd_block_t         pop_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ctbd_pkg::COORD_W-1:0]  m_pixel_x,
    output logic [ctbd_pkg::COORD_W-1:0]  m_pixel_y,
    output logic [7:0]                    m_red,
    output logic [7:0]                    m_green,
    output logic [7:0]                    m_blue,
    output logic [7:0]                    m_alpha,
    output logic                          m_last_of_block,
    output logic                          m_last_of_image
);
    import ctbd_pkg::*;

    ctbd_block_t        blk_reg;
    logic [31:0]        idx_reg, idx_next;
    logic [3:0]         pix_reg, pix_next;
    logic               have_reg, have_next;
    logic               out_valid_reg, out_valid_next;
    logic               advance, last_pix;
    logic [1:0]         sel;
    ctbd_rgb_t          color;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [7:0]         red_reg, green_reg, blue_reg, alpha_reg;
    logic               lob_reg, loi_reg;

    assign advance   = have_reg && (!out_valid_reg || m_ready);
    assign last_pix  = pix_reg == 4'd15;
    assign pop_ready = !have_reg || (advance && last_pix);
    assign sel       = idx_reg[31:30];
    assign color     = blk_reg.palette[sel];

    always_comb begin
        have_next = have_reg;
        pix_next  = pix_reg;
        idx_next  = idx_reg;
        if (advance) begin
            pix_next = pix_reg + 4'd1;
            idx_next = {idx_reg[29:0], 2'b00};
        end
        if (pop_ready) begin
            have_next = pop_valid;
            pix_next  = '0;
            idx_next  = pop_data.index_rows;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            blk_reg <= pop_data;
        end
        idx_reg <= idx_next;
        if (advance) begin
            px_reg    <= blk_reg.base_x | COORD_W'(pix_reg[1:0]);
            py_reg    <= blk_reg.base_y | COORD_W'(pix_reg[3:2]);
            red_reg   <= color.red;
            green_reg <= color.green;
            blue_reg  <= color.blue;
            alpha_reg <= (sel == 2'd3 && blk_reg.clear3) ? ALPHA_CLEAR : ALPHA_OPAQUE;
            lob_reg   <= last_pix;
            loi_reg   <= last_pix && blk_reg.image_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg      <= 1'b0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            have_reg      <= have_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_x       = px_reg;
    assign m_pixel_y       = py_reg;
    assign m_red           = red_reg;
    assign m_green         = green_reg;
    assign m_blue          = blue_reg;
    assign m_alpha         = alpha_reg;
    assign m_last_of_block = lob_reg;
    assign m_last_of_image = loi_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled block decoder testbench
// Streams compressed color blocks into the decoder and checks every decoded
// pixel against a predictor of the palette, tile walk and image-end flags.
// The image size is changed between phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_TILES   = ctbd_pkg::MAX_TILES_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [ctbd_pkg::COORD_W-1:0] x;
        logic [ctbd_pkg::COORD_W-1:0] y;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic [7:0]                   alpha;
        logic                         last_blk;
        logic                         last_img;
    } rgba_pixel_t;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

    class pixel_scoreboard;
        rgba_pixel_t expected_pixels[$];
        int across = 1;
        int down = 1;
        int column = 0;
        int row = 0;
        int sub_blk = 0;
        int failures = 0;
        int blocks = 0;
        int checked = 0;
        int images = 0;

        function int widen5(logic [4:0] v);
            return {v, v[4:2]};
        endfunction

        function int widen6(logic [5:0] v);
            return {v, v[5:4]};
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void resize(logic [0:0] which, logic [31:0] value);
            int s;
            s = value[7:0];
            if (s == 0) s = 1;
            if (s > MAX_TILES) s = MAX_TILES;
            if (which == ctbd_pkg::REG_TILES_ACROSS) across = s;
            else down = s;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) $display("%0t: %s", $realtime, msg);
        endfunction

        function void note_block(logic [15:0] c1, logic [15:0] c2, logic [31:0] rows);
            int pal [4][4];
            rgba_pixel_t p;
            int bx, by, sel;
            bit col_end, row_end, img_end;
            col_end = column + 1 >= across;
            row_end = row + 1 >= down;
            img_end = sub_blk == 3 && col_end && row_end;
            bx = column * 8 + (sub_blk % 2) * 4;
            by = row * 8 + (sub_blk / 2) * 4;
            pal[0][0] = widen5(c1[15:11]);
            pal[0][1] = widen6(c1[10:5]);
            pal[0][2] = widen5(c1[4:0]);
            pal[1][0] = widen5(c2[15:11]);
            pal[1][1] = widen6(c2[10:5]);
            pal[1][2] = widen5(c2[4:0]);
            for (int ch = 0; ch < 3; ch++) begin
                if (c1 > c2) begin
                    pal[2][ch] = (3 * pal[1][ch] + 5 * pal[0][ch]) >> 3;
                    pal[3][ch] = (3 * pal[0][ch] + 5 * pal[1][ch]) >> 3;
                end else begin
                    pal[2][ch] = (pal[0][ch] + pal[1][ch]) >> 1;
                    pal[3][ch] = pal[2][ch];
                end
            end
            pal[0][3] = ctbd_pkg::ALPHA_OPAQUE;
            pal[1][3] = ctbd_pkg::ALPHA_OPAQUE;
            pal[2][3] = ctbd_pkg::ALPHA_OPAQUE;
            pal[3][3] = (c1 > c2) ? ctbd_pkg::ALPHA_OPAQUE : ctbd_pkg::ALPHA_CLEAR;
            for (int k = 0; k < 16; k++) begin
                sel = (rows >> (30 - 8 * (k / 4) - 2 * (k % 4))) & 3;
                p.x = bx + k % 4;
                p.y = by + k / 4;
                p.red = pal[sel][0];
                p.green = pal[sel][1];
                p.blue = pal[sel][2];
                p.alpha = pal[sel][3];
                p.last_blk = (k == 15);
                p.last_img = (k == 15) && img_end;
                expected_pixels.push_back(p);
            end
            blocks++;
            if (sub_blk >= 3) begin
                sub_blk = 0;
                if (col_end) begin
                    column = 0;
                    row = row_end ? 0 : row + 1;
                end else begin
                    column++;
                end
            end else begin
                sub_blk++;
            end
        endfunction

        function void check_pixel(rgba_pixel_t got);
            rgba_pixel_t want;
            if (expected_pixels.size() == 0) begin
                note_failure($sformatf("pixel at x=%0d y=%0d with no block pending",
                                       got.x, got.y));
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (want.last_img) images++;
            if (got.x != want.x || got.y != want.y || got.red != want.red ||
                got.green != want.green || got.blue != want.blue ||
                got.alpha != want.alpha || got.last_blk != want.last_blk ||
                got.last_img != want.last_img) begin
                note_failure($sformatf(
                    "pixel mismatch: expected x=%0d y=%0d rgba=%02x%02x%02x%02x lb=%0b li=%0b, got x=%0d y=%0d rgba=%02x%02x%02x%02x lb=%0b li=%0b",
                    want.x, want.y, want.red, want.green, want.blue, want.alpha,
                    want.last_blk, want.last_img, got.x, got.y, got.red, got.green,
                    got.blue, got.alpha, got.last_blk, got.last_img));
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_endpoint_first = '0;
    logic [15:0] s_endpoint_second = '0;
    logic [31:0] s_index_rows = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [ctbd_pkg::COORD_W-1:0] m_pixel_x;
    logic [ctbd_pkg::COORD_W-1:0] m_pixel_y;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha;
    logic        m_last_of_block;
    logic        m_last_of_image;

    pixel_scoreboard sb = new();
    ready_mode_t ready_mode = READY_ALWAYS;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [15:0] stall_seed = 16'hFFFF;
    bit          stall_load = 1'b0;
    bit          long_hold_req = 1'b0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          cycles = 0;
    int          settings = 0;

    cmpr_tiled_block_decoder #(.MAX_TILES(MAX_TILES)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_endpoint_first(s_endpoint_first),
        .s_endpoint_second(s_endpoint_second),
        .s_index_rows(s_index_rows),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_red(m_red),
        .m_green(m_green),
        .m_blue(m_blue),
        .m_alpha(m_alpha),
        .m_last_of_block(m_last_of_block),
        .m_last_of_image(m_last_of_image)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_block(s_endpoint_first, s_endpoint_second, s_index_rows);
            end
            if (m_valid && m_ready) begin
                sb.check_pixel({m_pixel_x, m_pixel_y, m_red, m_green, m_blue, m_alpha,
                                m_last_of_block, m_last_of_image});
            end
        end
    end

    always @(posedge aclk) begin
        if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (stall_load) begin
            stall_pattern <= stall_seed;
            stall_load = 1'b0;
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_RANDOM: m_ready <= ($urandom_range(0, 99) < 65);
                default: m_ready <= stall_pattern[0];
            endcase
        end
    end

    task automatic reg_write(logic [0:0] which, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.resize(which, value);
        settings++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_size(logic [31:0] across, logic [31:0] down);
        drain();
        reg_write(ctbd_pkg::REG_TILES_ACROSS, across);
        reg_write(ctbd_pkg::REG_TILES_DOWN, down);
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        stall_seed = 16'($urandom) | 16'h0001;
        stall_load = 1'b1;
    endtask

    task automatic offer_block(logic [15:0] c1, logic [15:0] c2, logic [31:0] rows);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_endpoint_first <= c1;
        s_endpoint_second <= c2;
        s_index_rows <= rows;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(int count);
        logic [15:0] c1, c2;
        repeat (count) begin
            c1 = $urandom;
            c2 = ($urandom_range(0, 5) == 0) ? c1 : 16'($urandom);
            offer_block(c1, c2, $urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default one-tile image: every group of four blocks ends an image.
        offer_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4);
        offer_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4);
        offer_block(16'h1234, 16'h1234, 32'hE4E4E4E4);
        offer_block(16'h0000, 16'h0000, 32'hFFFFFFFF);
        offer_block(16'hFFFF, 16'hFFFF, 32'h00000000);
        offer_block(16'hF800, 16'h07E0, 32'h1B1B1B1B);
        offer_block(16'h07E0, 16'h001F, 32'h27D88D72);
        offer_block(16'h001F, 16'hF800, 32'hAAAAAAAA);
        offer_block(16'h0001, 16'h0000, 32'h55555555);
        offer_block(16'h0000, 16'h0001, 32'hFFFFFFFF);
        offer_block(16'h8410, 16'h7BEF, 32'hE4E41B1B);
        offer_block(16'h7BEF, 16'h8410, 32'h1B1BE4E4);
        offer_block(16'hFFFE, 16'hFFFF, 32'hC3C33C3C);
        offer_block(16'hFFFF, 16'hFFFE, 32'h3C3CC3C3);
        offer_block(16'hF81F, 16'h07E0, 32'h0F0FF0F0);
        offer_block(16'h07FF, 16'hF800, 32'h96966969);

        set_size(32'd3, 32'd2);
        send_random(24);

        // Shrinking mid-image leaves the counters past the new size.
        set_size(32'd4, 32'd4);
        send_random(22);
        set_size(32'd0, 32'h0000_0100);
        send_random(10);

        // Oversize values clamp; the output stalls long enough to back up the input.
        set_size(32'hFFFF_FFFF, 32'd128);
        ready_mode = READY_ALWAYS;
        long_hold_req = 1'b1;
        burst_left = 40;
        send_random(16);

        set_size(32'd1, 32'd200);
        send_random(12);

        repeat (5) begin
            set_size({24'($urandom), 8'($urandom_range(0, 3))},
                     {24'($urandom), 8'($urandom_range(0, 3))});
            send_random($urandom_range(8, 16));
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("Checked %0d pixels from %0d blocks, %0d image ends, over %0d size writes,",
                 sb.checked, sb.blocks, sb.images, settings);
        $display("with clamped and mid-image size changes and a long output stall.");
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
